>>> src/rws_pkg.sv
package rws_pkg;

  localparam int unsigned MaxPopulation = 128;
  localparam int unsigned FitW          = 32;
  localparam int unsigned SlotW         = 7;
  localparam int unsigned CountW        = 8;
  localparam int unsigned StatusW       = 2;
  localparam int unsigned ProdW         = 2 * FitW;

  localparam logic [CountW-1:0] ActiveReset = 8'd100;

  typedef enum logic [0:0] {
    ACT_LOAD   = 1'b0,
    ACT_SELECT = 1'b1
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Controls for the shared accumulate / multiply unit.
  typedef struct packed {
    logic acc_clr;
    logic acc_add;
    logic mul_lo;
    logic mul_hi;
    logic tgt_add;
  } arith_ctl_t;

endpackage

>>> src/rws_in_if.sv
interface rws_in_if;
  logic                         valid;
  logic                         ready;
  logic [0:0]                   action;
  logic [rws_pkg::SlotW-1:0]    slot_index;
  logic [rws_pkg::FitW-1:0]     fitness_value;
  logic [rws_pkg::FitW-1:0]     random_fraction;

  modport source (output valid, action, slot_index, fitness_value, random_fraction,
                  input ready);
  modport sink (input valid, action, slot_index, fitness_value, random_fraction,
                output ready);
endinterface

>>> src/rws_out_if.sv
interface rws_out_if;
  logic                         valid;
  logic                         ready;
  logic [rws_pkg::SlotW-1:0]    chosen_slot;
  logic [rws_pkg::StatusW-1:0]  status;

  modport source (output valid, chosen_slot, status, input ready);
  modport sink (input valid, chosen_slot, status, output ready);
endinterface

>>> src/rws_cfg_if.sv
interface rws_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rws_pkg::CountW-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> src/rws_store.sv
module rws_store #(
  parameter int unsigned Depth = rws_pkg::MaxPopulation,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [rws_pkg::FitW-1:0]  wr_data_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [rws_pkg::FitW-1:0]  rd_data_o
);
  import rws_pkg::*;

  logic [FitW-1:0] mem_q [Depth];
  logic [FitW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/rws_arith.sv
module rws_arith #(
  parameter int unsigned WheelW = 40
) (
  input  logic                       clk_i,
  input  rws_pkg::arith_ctl_t        ctl_i,
  input  logic [rws_pkg::FitW-1:0]   rfrac_i,
  input  logic [rws_pkg::FitW-1:0]   rd_data_i,
  output logic [WheelW-1:0]          wheel_o,
  output logic                       hit_o
);
  import rws_pkg::*;

  logic [WheelW-1:0] acc_q;
  logic [WheelW-1:0] tgt_q;
  logic [ProdW-1:0]  prod_q;
  logic [WheelW-1:0] sum;
  logic [FitW-1:0]   mul_b;
  logic [ProdW-1:0]  prod;

  assign sum   = acc_q + WheelW'(rd_data_i);
  assign hit_o = sum > tgt_q;

  // The wheel total is split into a low word and a high part, so one
  // 32 by 32 multiplier serves both partial products.
  assign mul_b = ctl_i.mul_hi ? FitW'(acc_q[WheelW-1:FitW]) : acc_q[FitW-1:0];
  assign prod  = rfrac_i * mul_b;

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctl_i.acc_add) begin
      acc_q <= sum;
    end
    if (ctl_i.mul_lo || ctl_i.mul_hi) begin
      prod_q <= prod;
    end
    if (ctl_i.mul_hi) begin
      tgt_q <= WheelW'(prod_q[ProdW-1:FitW]);
    end else if (ctl_i.tgt_add) begin
      // The true target lies below the wheel total, so modular addition holds.
      tgt_q <= tgt_q + WheelW'(prod_q);
    end
  end

  assign wheel_o = acc_q;

endmodule

>>> src/roulette_wheel_selector.sv
// Fitness-proportionate selector for a genetic algorithm.
// Requests arrive on in_i: a load request writes fitness_value into slot
// slot_index, a select request draws a slot with the Q0.32 random_fraction.
// Every request gives exactly one response on out_o (chosen_slot, status).
// cfg_i writes the active slot count; it is always ready and should only be
// written while no request is in flight.
// The response to a load request passes through S_RESP into the output
// register, and in_i is ready again as soon as that response is valid.
// A select over the N active slots runs as follows: one pass over the fitness
// memory sums the wheel, the shared multiplier forms the target in three
// steps, and a second pass over the memory finds the slot. Both passes read
// one entry a cycle through the single read port. in_i is not ready while a
// request is being worked on.
// After reset the fitness memory is cleared, one entry a cycle; in_i stays
// low on ready until that is done.
// The response sits in an output register; while the receiver stalls the
// next request is still accepted and worked on, then waits for that register.
module roulette_wheel_selector #(
  parameter int unsigned MAX_POPULATION = rws_pkg::MaxPopulation
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rws_cfg_if.sink   cfg_i,
  rws_in_if.sink    in_i,
  rws_out_if.source out_o
);
  import rws_pkg::*;

  localparam int unsigned AddrW  = $clog2(MAX_POPULATION);
  localparam int unsigned Lim    = (MAX_POPULATION < 255) ? MAX_POPULATION : 255;
  localparam int unsigned CntW   = $clog2(Lim + 1);
  localparam int unsigned WheelW = FitW + CntW;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SUM   = 8'b0000_0100,
    S_MLO   = 8'b0000_1000,
    S_MHI   = 8'b0001_0000,
    S_TGT   = 8'b0010_0000,
    S_WALK  = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CountW-1:0] active_q;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic              rv_q, rv_d;
  logic [AddrW-1:0]  didx_q, didx_d;
  logic [FitW-1:0]   rfrac_q, rfrac_d;
  logic [SlotW-1:0]  res_slot_q, res_slot_d;
  status_e           res_status_q, res_status_d;
  logic              out_valid_q;
  logic [SlotW-1:0]  out_slot_q;
  status_e           out_status_q;

  logic [CntW-1:0]   eff;
  logic              in_acc;
  logic              in_range;
  logic              issue;
  logic              out_load;
  arith_ctl_t        ctl;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [FitW-1:0]   wr_data;
  logic [FitW-1:0]   rd_data;
  logic [WheelW-1:0] wheel;
  logic              hit;

  assign eff      = (active_q >= CountW'(Lim)) ? CntW'(Lim) : CntW'(active_q);
  assign in_acc   = in_i.valid && in_i.ready;
  assign in_range = {1'b0, in_i.slot_index} < CountW'(eff);
  assign out_load = (state_q == S_RESP) && (!out_valid_q || out_o.ready);

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  rws_store #(
    .Depth (MAX_POPULATION)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (AddrW'(idx_q)),
    .rd_data_o (rd_data)
  );

  rws_arith #(
    .WheelW (WheelW)
  ) u_arith (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .rfrac_i   (rfrac_q),
    .rd_data_i (rd_data),
    .wheel_o   (wheel),
    .hit_o     (hit)
  );

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    idx_d        = idx_q;
    rv_d         = 1'b0;
    didx_d       = didx_q;
    rfrac_d      = rfrac_q;
    res_slot_d   = res_slot_q;
    res_status_d = res_status_q;
    ctl          = '0;
    wr_en        = 1'b0;
    wr_addr      = clr_q;
    wr_data      = '0;
    issue        = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(MAX_POPULATION - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.action == ACT_SELECT) begin
            rfrac_d     = in_i.random_fraction;
            idx_d       = '0;
            ctl.acc_clr = 1'b1;
            state_d     = S_SUM;
          end else begin
            res_slot_d = '0;
            if (in_range) begin
              wr_en        = 1'b1;
              wr_addr      = AddrW'(in_i.slot_index);
              wr_data      = in_i.fitness_value;
              res_status_d = ST_OK;
            end else begin
              res_status_d = ST_RANGE;
            end
            state_d = S_RESP;
          end
        end
      end
      S_SUM: begin
        issue = (idx_q != eff);
        rv_d  = issue;
        if (issue) begin
          idx_d  = idx_q + 1'b1;
          didx_d = AddrW'(idx_q);
        end
        if (rv_q) begin
          ctl.acc_add = 1'b1;
        end
        if (!issue && !rv_q) begin
          if (wheel == '0) begin
            res_slot_d   = '0;
            res_status_d = ST_ZERO;
            state_d      = S_RESP;
          end else begin
            state_d = S_MLO;
          end
        end
      end
      S_MLO: begin
        ctl.mul_lo = 1'b1;
        state_d    = S_MHI;
      end
      S_MHI: begin
        ctl.mul_hi = 1'b1;
        state_d    = S_TGT;
      end
      S_TGT: begin
        ctl.tgt_add = 1'b1;
        ctl.acc_clr = 1'b1;
        idx_d       = '0;
        state_d     = S_WALK;
      end
      S_WALK: begin
        issue = (idx_q != eff);
        rv_d  = issue;
        if (issue) begin
          idx_d  = idx_q + 1'b1;
          didx_d = AddrW'(idx_q);
        end
        if (rv_q && hit) begin
          res_slot_d   = SlotW'(didx_q);
          res_status_d = ST_OK;
          state_d      = S_RESP;
        end else if (rv_q) begin
          ctl.acc_add = 1'b1;
        end else if (!issue) begin
          res_slot_d   = '0;
          res_status_d = ST_ZERO;
          state_d      = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      idx_q       <= '0;
      rv_q        <= 1'b0;
      active_q    <= ActiveReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      idx_q   <= idx_d;
      rv_q    <= rv_d;
      if (cfg_i.valid && cfg_i.ready) begin
        active_q <= cfg_i.data;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    didx_q       <= didx_d;
    rfrac_q      <= rfrac_d;
    res_slot_q   <= res_slot_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_slot_q   <= res_slot_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.chosen_slot = out_slot_q;
  assign out_o.status      = out_status_q;

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM || state_q == S_WALK) |-> idx_q <= eff)
    else $error("walk index ran past the active count");

  a_err_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_OK) |-> out_o.chosen_slot == '0)
    else $error("error response carries a non-zero slot");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("request taken while the previous one is still at work");

  a_clear_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q == S_CLEAR) |-> state_q == S_IDLE)
    else $error("clearing pass left to a state other than idle");

  a_walk_has_wheel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM && state_d == S_MLO) |-> wheel != '0)
    else $error("multiply started on a zero wheel total");
`endif

endmodule
